[sv/mis_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mis_pkg
// Shared types and constants for the merged interval set with undo.
// ----------------------------------------------------------------------------
package mis_pkg;

   localparam int TIME_W        = 32;
   localparam int MAX_INTERVALS = 64;   // power of two keeps bank addressing dense
   localparam int IDX_W         = $clog2(MAX_INTERVALS);
   localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
   localparam int BANKS         = 3;
   localparam int BANK_W        = 2;
   localparam int ADDR_W        = BANK_W + IDX_W;
   localparam int MEM_DEPTH     = BANKS * MAX_INTERVALS;
   localparam int ACT_W         = 3;
   localparam int STAT_W        = 3;
   localparam int MINLEN_W      = 16;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 32;

   // action codes
   localparam logic [ACT_W-1:0] ACT_ADD   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_UNDO  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd2;
   localparam logic [ACT_W-1:0] ACT_QUERY = 3'd3;
   localparam logic [ACT_W-1:0] ACT_SETPH = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_NO_MEDIA = 3'd1;
   localparam logic [STAT_W-1:0] ST_SHORT    = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STAT_W-1:0] ST_NO_UNDO  = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MEDIA   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TSTART  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEND    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MINLEN  = 2'd3;

   localparam logic [MINLEN_W-1:0] MINLEN_RESET = 16'd50;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] end_time;
      logic [TIME_W-1:0] point_time;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              is_cut;
      logic [TIME_W-1:0] cut_start;
      logic [TIME_W-1:0] cut_end;
      logic [TIME_W-1:0] resume_time;
      logic [TIME_W-1:0] playhead_now;
      logic [CNT_W-1:0]  stored_count;
      logic              undo_available;
   } rsp_type;

   typedef struct packed {
      logic                media_present;
      logic [TIME_W-1:0]   trim_start;
      logic [TIME_W-1:0]   trim_end;
      logic [MINLEN_W-1:0] min_cut_length;
   } cfg_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [TIME_W-1:0] wstart;
      logic [TIME_W-1:0] wend;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic [TIME_W-1:0] rstart;
      logic [TIME_W-1:0] rend;
   } mem_rsp_type;

endpackage

[sv/mis_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mis_store
// Interval storage: three banks (live, snapshot, scratch), one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module mis_store (
   input  logic                 clock,
   input  mis_pkg::mem_req_type mem_req,
   output mis_pkg::mem_rsp_type mem_rsp
);
   import mis_pkg::*;

   logic [2*TIME_W-1:0] mem [0:MEM_DEPTH-1];
   logic [2*TIME_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= {mem_req.wstart, mem_req.wend};
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rdata_ff <= mem[mem_req.raddr];
      end
   end

   assign mem_rsp.rstart = rdata_ff[2*TIME_W-1:TIME_W];
   assign mem_rsp.rend   = rdata_ff[TIME_W-1:0];

endmodule

[sv/mis_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mis_ctrl
// Sequencer: merge walk for add, containment scan for query and playhead,
// bank rotation for snapshot and undo.
// ----------------------------------------------------------------------------
module mis_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  mis_pkg::req_type     req,
   input  mis_pkg::cfg_type     cfg,
   output mis_pkg::mem_req_type mem_req,
   input  mis_pkg::mem_rsp_type mem_rsp,
   output logic                 rsp_valid,
   output mis_pkg::rsp_type     rsp
);
   import mis_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_ADD_CLAMP = 4'd1;
   localparam logic [3:0] S_ADD_CHK   = 4'd2;
   localparam logic [3:0] S_M_FETCH   = 4'd3;
   localparam logic [3:0] S_M_MERGE   = 4'd4;
   localparam logic [3:0] S_M_TAIL    = 4'd5;
   localparam logic [3:0] S_M_FLUSH   = 4'd6;
   localparam logic [3:0] S_PH_PREP   = 4'd7;
   localparam logic [3:0] S_SC_FETCH  = 4'd8;
   localparam logic [3:0] S_SC_CHK    = 4'd9;
   localparam logic [3:0] S_SC_END    = 4'd10;
   localparam logic [3:0] S_DONE      = 4'd11;

   function automatic logic [TIME_W-1:0] clamp_trim(input logic [TIME_W-1:0] v,
                                                    input logic [TIME_W-1:0] lo,
                                                    input logic [TIME_W-1:0] hi);
      logic [TIME_W-1:0] r;
      r = (v < lo) ? lo : v;
      if (r > hi) begin
         r = hi;
      end
      return r;
   endfunction

   logic [3:0]        state_ff, state_in;
   logic [ACT_W-1:0]  act_ff, act_in;
   logic [TIME_W-1:0] s_ff, s_in, e_ff, e_in, pt_ff, pt_in;
   logic [CNT_W-1:0]  idx_ff, idx_in, w_ff, w_in;
   logic              full_ff, full_in, ins_ff, ins_in, pend_v_ff, pend_v_in;
   logic [TIME_W-1:0] ps_ff, ps_in, pe_ff, pe_in;
   logic              hit_ff, hit_in;
   logic [TIME_W-1:0] hs_ff, hs_in, he_ff, he_in;
   logic [BANK_W-1:0] live_ff, live_in, snap_ff, snap_in, scr_ff, scr_in;
   logic [CNT_W-1:0]  count_ff, count_in, snap_cnt_ff, snap_cnt_in;
   logic              snap_v_ff, snap_v_in;
   logic [TIME_W-1:0] play_ff, play_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // merge element feed
   logic              el_go;
   logic [TIME_W-1:0] el_s, el_e, skip_t;

   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      s_in        = s_ff;
      e_in        = e_ff;
      pt_in       = pt_ff;
      idx_in      = idx_ff;
      w_in        = w_ff;
      full_in     = full_ff;
      ins_in      = ins_ff;
      pend_v_in   = pend_v_ff;
      ps_in       = ps_ff;
      pe_in       = pe_ff;
      hit_in      = hit_ff;
      hs_in       = hs_ff;
      he_in       = he_ff;
      live_in     = live_ff;
      snap_in     = snap_ff;
      scr_in      = scr_ff;
      count_in    = count_ff;
      snap_cnt_in = snap_cnt_ff;
      snap_v_in   = snap_v_ff;
      play_in     = play_ff;
      status_in   = status_ff;
      rsp_valid_in = 1'b0;
      rsp_in      = rsp_ff;
      mem_req     = '0;
      el_go       = 1'b0;
      el_s        = s_ff;
      el_e        = e_ff;
      skip_t      = hit_ff ? he_ff : pt_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in    = req.action;
               status_in = ST_OK;
               hit_in    = 1'b0;
               hs_in     = '0;
               he_in     = '0;
               idx_in    = '0;
               case (req.action)
                  ACT_ADD: begin
                     s_in     = req.start_time;
                     e_in     = req.end_time;
                     state_in = S_ADD_CLAMP;
                  end
                  ACT_UNDO: begin
                     if (!snap_v_ff) begin
                        status_in = ST_NO_UNDO;
                        state_in  = S_DONE;
                     end else begin
                        live_in     = snap_ff;
                        snap_in     = live_ff;
                        count_in    = snap_cnt_ff;
                        snap_cnt_in = '0;
                        snap_v_in   = 1'b0;
                        pt_in       = play_ff;
                        state_in    = S_PH_PREP;
                     end
                  end
                  ACT_CLEAR: begin
                     count_in    = '0;
                     snap_cnt_in = '0;
                     snap_v_in   = 1'b0;
                     state_in    = S_DONE;
                  end
                  ACT_QUERY: begin
                     pt_in    = req.point_time;
                     state_in = S_SC_FETCH;
                  end
                  ACT_SETPH: begin
                     pt_in    = req.point_time;
                     state_in = S_PH_PREP;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // order the bounds, then pull them into the trim window
         S_ADD_CLAMP: begin
            s_in = clamp_trim((e_ff < s_ff) ? e_ff : s_ff, cfg.trim_start, cfg.trim_end);
            e_in = clamp_trim((e_ff < s_ff) ? s_ff : e_ff, cfg.trim_start, cfg.trim_end);
            state_in = S_ADD_CHK;
         end

         S_ADD_CHK: begin
            if (!cfg.media_present) begin
               status_in = ST_NO_MEDIA;
               state_in  = S_DONE;
            end else if ((e_ff < s_ff) ||
                         ((e_ff - s_ff) < {{(TIME_W-MINLEN_W){1'b0}}, cfg.min_cut_length})) begin
               status_in = ST_SHORT;
               state_in  = S_DONE;
            end else begin
               idx_in    = '0;
               w_in      = '0;
               full_in   = 1'b0;
               ins_in    = 1'b0;
               pend_v_in = 1'b0;
               state_in  = S_M_FETCH;
            end
         end

         S_M_FETCH: begin
            if (idx_ff == count_ff) begin
               state_in = S_M_TAIL;
            end else begin
               mem_req.re    = 1'b1;
               mem_req.raddr = {live_ff, idx_ff[IDX_W-1:0]};
               state_in      = S_M_MERGE;
            end
         end

         // new interval goes in ahead of the first entry starting after it
         S_M_MERGE: begin
            el_go = 1'b1;
            if (!ins_ff && (mem_rsp.rstart > s_ff)) begin
               ins_in = 1'b1;
            end else begin
               el_s     = mem_rsp.rstart;
               el_e     = mem_rsp.rend;
               idx_in   = idx_ff + 1'b1;
               state_in = S_M_FETCH;
            end
         end

         S_M_TAIL: begin
            if (!ins_ff) begin
               el_go  = 1'b1;
               ins_in = 1'b1;
            end else begin
               state_in = S_M_FLUSH;
            end
         end

         // last pending interval, then commit or reject
         S_M_FLUSH: begin
            if (full_ff || (w_ff == CNT_W'(MAX_INTERVALS))) begin
               status_in = ST_FULL;
               state_in  = S_DONE;
            end else begin
               mem_req.we     = 1'b1;
               mem_req.waddr  = {scr_ff, w_ff[IDX_W-1:0]};
               mem_req.wstart = ps_ff;
               mem_req.wend   = pe_ff;
               live_in        = scr_ff;
               snap_in        = live_ff;
               scr_in         = snap_ff;
               snap_cnt_in    = count_ff;
               count_in       = w_ff + 1'b1;
               snap_v_in      = 1'b1;
               pt_in          = play_ff;
               state_in       = S_PH_PREP;
            end
         end

         S_PH_PREP: begin
            if (!cfg.media_present) begin
               play_in  = '0;
               state_in = S_DONE;
            end else begin
               pt_in    = clamp_trim(pt_ff, cfg.trim_start, cfg.trim_end);
               idx_in   = '0;
               hit_in   = 1'b0;
               state_in = S_SC_FETCH;
            end
         end

         S_SC_FETCH: begin
            if (idx_ff == count_ff) begin
               state_in = S_SC_END;
            end else begin
               mem_req.re    = 1'b1;
               mem_req.raddr = {live_ff, idx_ff[IDX_W-1:0]};
               state_in      = S_SC_CHK;
            end
         end

         S_SC_CHK: begin
            if ((pt_ff >= mem_rsp.rstart) && (pt_ff < mem_rsp.rend)) begin
               hit_in   = 1'b1;
               hs_in    = mem_rsp.rstart;
               he_in    = mem_rsp.rend;
               state_in = S_SC_END;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SC_FETCH;
            end
         end

         // merged entries never touch, so one skip is final
         S_SC_END: begin
            if (act_ff != ACT_QUERY) begin
               play_in = (skip_t > cfg.trim_end) ? cfg.trim_end : skip_t;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            rsp_valid_in          = 1'b1;
            rsp_in.status         = status_ff;
            rsp_in.is_cut         = (act_ff == ACT_QUERY) && hit_ff;
            rsp_in.cut_start      = (act_ff == ACT_QUERY) ? hs_ff : '0;
            rsp_in.cut_end        = (act_ff == ACT_QUERY) ? he_ff : '0;
            rsp_in.resume_time    = (act_ff == ACT_QUERY) ? skip_t : '0;
            rsp_in.playhead_now   = play_ff;
            rsp_in.stored_count   = count_ff;
            rsp_in.undo_available = snap_v_ff;
            state_in              = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // streaming merge of one element against the pending interval
      if (el_go) begin
         if (!pend_v_ff) begin
            pend_v_in = 1'b1;
            ps_in     = el_s;
            pe_in     = el_e;
         end else if (el_s > pe_ff) begin
            if (w_ff == CNT_W'(MAX_INTERVALS)) begin
               full_in = 1'b1;
            end else begin
               mem_req.we     = 1'b1;
               mem_req.waddr  = {scr_ff, w_ff[IDX_W-1:0]};
               mem_req.wstart = ps_ff;
               mem_req.wend   = pe_ff;
               w_in           = w_ff + 1'b1;
            end
            ps_in = el_s;
            pe_in = el_e;
         end else if (el_e > pe_ff) begin
            pe_in = el_e;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         live_ff      <= 2'd0;
         snap_ff      <= 2'd1;
         scr_ff       <= 2'd2;
         count_ff     <= '0;
         snap_cnt_ff  <= '0;
         snap_v_ff    <= 1'b0;
         play_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         snap_ff      <= snap_in;
         scr_ff       <= scr_in;
         count_ff     <= count_in;
         snap_cnt_ff  <= snap_cnt_in;
         snap_v_ff    <= snap_v_in;
         play_ff      <= play_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      s_ff      <= s_in;
      e_ff      <= e_in;
      pt_ff     <= pt_in;
      idx_ff    <= idx_in;
      w_ff      <= w_in;
      full_ff   <= full_in;
      ins_ff    <= ins_in;
      pend_v_ff <= pend_v_in;
      ps_ff     <= ps_in;
      pe_ff     <= pe_in;
      hit_ff    <= hit_in;
      hs_ff     <= hs_in;
      he_ff     <= he_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[sv/merged_interval_set_with_undo_core.sv]
`timescale 1ns / 1ps
// An add runs the merge walk, then the playhead scan, both reading stored entries through
// the one memory read port; query runs the containment scan, undo and set-playhead the
// playhead scan (skipped without media); clear, unused codes and an empty undo go straight
// to the result, as does an add without media or too short. A full store rejects an add
// after the merge walk. One item at a time, busy drops as the strobe rises.
// Reset: set, snapshot and playhead empty, registers at defaults, no clearing pass.
// ----------------------------------------------------------------------------
// merged_interval_set_with_undo_core
// Sorted disjoint interval set with one-level undo and a playhead.
// ----------------------------------------------------------------------------
module merged_interval_set_with_undo_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  mis_pkg::req_type                    req,
   input  logic                                csr_we,
   input  logic [mis_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mis_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                rsp_valid,
   output mis_pkg::rsp_type                    rsp
);
   import mis_pkg::*;

   cfg_type     cfg_ff;
   mem_req_type mem_req;
   mem_rsp_type mem_rsp;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.media_present  <= 1'b0;
         cfg_ff.trim_start     <= '0;
         cfg_ff.trim_end       <= '0;
         cfg_ff.min_cut_length <= MINLEN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MEDIA:  cfg_ff.media_present  <= csr_wdata[0];
            CSR_TSTART: cfg_ff.trim_start     <= csr_wdata[TIME_W-1:0];
            CSR_TEND:   cfg_ff.trim_end       <= csr_wdata[TIME_W-1:0];
            CSR_MINLEN: cfg_ff.min_cut_length <= csr_wdata[MINLEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   mis_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

   mis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .cfg       (cfg_ff),
      .mem_req   (mem_req),
      .mem_rsp   (mem_rsp),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the merged interval set with undo.
// Drives add, undo, clear, query and set-playhead transactions with random
// gaps, predicts each result from an in-bench model of the interval store,
// playhead and snapshot, and compares every result field by field.
// ----------------------------------------------------------------------------
module tb;
   import mis_pkg::*;

   localparam int IDLE_LIMIT = 5000;
   localparam int END_WAIT   = 300;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  rsp_valid;
   rsp_type               rsp;

   merged_interval_set_with_undo_core u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   // clock, 4 ns period
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // predicted state of the block
   // ---------------------------------------------------------------------
   logic              m_media;
   logic [TIME_W-1:0] m_tstart;
   logic [TIME_W-1:0] m_tend;
   logic [MINLEN_W-1:0] m_minlen;
   logic [TIME_W-1:0] set_s [MAX_INTERVALS];
   logic [TIME_W-1:0] set_e [MAX_INTERVALS];
   int                set_n;
   logic [TIME_W-1:0] snap_s [MAX_INTERVALS];
   logic [TIME_W-1:0] snap_e [MAX_INTERVALS];
   int                snap_n;
   bit                snap_ok;
   logic [TIME_W-1:0] playhead;

   rsp_type expected_rsp_q[$];
   int      errors;
   int      n_items;
   int      n_results;
   int      n_add_ok;
   int      n_full;
   int      n_cut_hits;
   bit      no_gaps;

   function automatic logic [TIME_W-1:0] trim_clamp(logic [TIME_W-1:0] v);
      if (v < m_tstart) return m_tstart;
      if (v > m_tend) return m_tend;
      return v;
   endfunction

   // index of the interval holding t, or set_n when none
   function automatic int find_cut(logic [TIME_W-1:0] t);
      for (int i = 0; i < set_n; i++)
         if (t >= set_s[i] && t < set_e[i]) return i;
      return set_n;
   endfunction

   function automatic logic [TIME_W-1:0] skip_cuts(logic [TIME_W-1:0] t);
      int k;
      for (int g = 0; g <= MAX_INTERVALS; g++) begin
         k = find_cut(t);
         if (k >= set_n) break;
         t = set_e[k];
      end
      return t;
   endfunction

   function automatic void settle_playhead();
      if (!m_media) begin
         playhead = '0;
         return;
      end
      playhead = skip_cuts(trim_clamp(playhead));
      if (playhead > m_tend) playhead = m_tend;
   endfunction

   function automatic logic [STAT_W-1:0] insert_cut(logic [TIME_W-1:0] s0,
                                                    logic [TIME_W-1:0] e0);
      logic [TIME_W-1:0] s, e, t;
      logic [TIME_W-1:0] ws [MAX_INTERVALS+1];
      logic [TIME_W-1:0] we_ [MAX_INTERVALS+1];
      int n, w, pos;
      if (!m_media) return ST_NO_MEDIA;
      s = s0;
      e = e0;
      if (e < s) begin
         t = s; s = e; e = t;
      end
      s = trim_clamp(s);
      e = trim_clamp(e);
      if (e < s || (e - s) < {16'd0, m_minlen}) return ST_SHORT;
      // sorted insert, then merge overlapping or touching entries
      pos = 0;
      while (pos < set_n && set_s[pos] <= s) pos++;
      n = 0;
      for (int i = 0; i < set_n; i++) begin
         if (i == pos) begin
            ws[n] = s; we_[n] = e; n++;
         end
         ws[n] = set_s[i]; we_[n] = set_e[i]; n++;
      end
      if (pos == set_n) begin
         ws[n] = s; we_[n] = e; n++;
      end
      w = 0;
      for (int i = 0; i < n; i++) begin
         if (w == 0 || ws[i] > we_[w-1]) begin
            ws[w] = ws[i]; we_[w] = we_[i]; w++;
         end else if (we_[i] > we_[w-1]) begin
            we_[w-1] = we_[i];
         end
      end
      if (w > MAX_INTERVALS) return ST_FULL;
      snap_s = set_s;
      snap_e = set_e;
      snap_n = set_n;
      snap_ok = 1'b1;
      for (int i = 0; i < w; i++) begin
         set_s[i] = ws[i]; set_e[i] = we_[i];
      end
      set_n = w;
      settle_playhead();
      return ST_OK;
   endfunction

   // one accepted transaction -> predicted result
   function automatic rsp_type predict_edit(req_type r);
      rsp_type o;
      int k;
      o = '0;
      case (r.action)
         ACT_ADD: begin
            o.status = insert_cut(r.start_time, r.end_time);
            if (o.status == ST_OK) n_add_ok++;
            if (o.status == ST_FULL) n_full++;
         end
         ACT_UNDO: begin
            if (!snap_ok) o.status = ST_NO_UNDO;
            else begin
               set_s = snap_s;
               set_e = snap_e;
               set_n = snap_n;
               snap_n = 0;
               snap_ok = 1'b0;
               settle_playhead();
            end
         end
         ACT_CLEAR: begin
            set_n = 0;
            snap_n = 0;
            snap_ok = 1'b0;
         end
         ACT_QUERY: begin
            k = find_cut(r.point_time);
            if (k < set_n) begin
               o.is_cut = 1'b1;
               o.cut_start = set_s[k];
               o.cut_end = set_e[k];
               n_cut_hits++;
            end
            o.resume_time = skip_cuts(r.point_time);
         end
         ACT_SETPH: begin
            playhead = r.point_time;
            settle_playhead();
         end
         default: ;
      endcase
      o.playhead_now = playhead;
      o.stored_count = set_n[CNT_W-1:0];
      o.undo_available = snap_ok;
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // driving
   // ---------------------------------------------------------------------
   task automatic send_edit(input req_type r);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req <= r;
      // start and busy only move at rising edges, so the level seen at the
      // falling edge is what the next rising edge samples
      do @(negedge clock); while (busy);
      @(posedge clock);
      expected_rsp_q.push_back(predict_edit(r));
      n_items++;
   endtask

   task automatic send_fields(input logic [ACT_W-1:0] a, input logic [TIME_W-1:0] s,
                              input logic [TIME_W-1:0] e, input logic [TIME_W-1:0] p);
      req_type r;
      r.action = a;
      r.start_time = s;
      r.end_time = e;
      r.point_time = p;
      send_edit(r);
   endtask

   // drain outstanding results, then write all four registers
   task automatic set_config(input logic media, input logic [TIME_W-1:0] ts,
                             input logic [TIME_W-1:0] te, input logic [MINLEN_W-1:0] ml);
      start <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_MEDIA;  csr_wdata <= {31'd0, media};
      @(posedge clock);
      csr_index <= CSR_TSTART; csr_wdata <= ts;
      @(posedge clock);
      csr_index <= CSR_TEND;   csr_wdata <= te;
      @(posedge clock);
      csr_index <= CSR_MINLEN; csr_wdata <= {16'd0, ml};
      @(posedge clock);
      csr_we <= 1'b0;
      m_media = media;
      m_tstart = ts;
      m_tend = te;
      m_minlen = ml;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                  input logic [TIME_W-1:0] want);
      errors++;
      if (errors <= 30)
         $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
   endtask

   always @(negedge clock) begin
      rsp_type x;
      if (!reset && rsp_valid) begin
         n_results++;
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("unexpected transaction", TIME_W'(rsp.status), '0);
         end else begin
            x = expected_rsp_q.pop_front();
            if (rsp.status !== x.status)
               report_mismatch("status", TIME_W'(rsp.status), TIME_W'(x.status));
            if (rsp.is_cut !== x.is_cut)
               report_mismatch("is_cut", TIME_W'(rsp.is_cut), TIME_W'(x.is_cut));
            if (rsp.cut_start !== x.cut_start)
               report_mismatch("cut_start", rsp.cut_start, x.cut_start);
            if (rsp.cut_end !== x.cut_end) report_mismatch("cut_end", rsp.cut_end, x.cut_end);
            if (rsp.resume_time !== x.resume_time)
               report_mismatch("resume_time", rsp.resume_time, x.resume_time);
            if (rsp.playhead_now !== x.playhead_now)
               report_mismatch("playhead_now", rsp.playhead_now, x.playhead_now);
            if (rsp.stored_count !== x.stored_count)
               report_mismatch("stored_count", TIME_W'(rsp.stored_count),
                               TIME_W'(x.stored_count));
            if (rsp.undo_available !== x.undo_available)
               report_mismatch("undo_available", TIME_W'(rsp.undo_available),
                               TIME_W'(x.undo_available));
         end
      end
   end

   // watchdog: cycles with no transaction on either side
   int idle_cycles;
   always @(negedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL merged_interval_set_with_undo_core");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_no_media();
      send_fields(ACT_ADD, 32'd100, 32'd500, 32'd0);
      send_fields(ACT_UNDO, 32'd0, 32'd0, 32'd0);
      send_fields(ACT_SETPH, 32'd0, 32'd0, 32'hFFFF_FFFF);
      send_fields(ACT_QUERY, 32'd0, 32'd0, 32'd1234);
      send_fields(ACT_CLEAR, 32'd0, 32'd0, 32'd0);
      send_fields(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_fields(3'd6, 32'd0, 32'd0, 32'd0);
      send_fields(3'd7, 32'd0, 32'd0, 32'd0);
   endtask

   task automatic test_basic_edits();
      set_config(1'b1, 32'd0, 32'hFFFF_FFFF, MINLEN_RESET);
      send_fields(ACT_ADD, 32'd1000, 32'd1049, 32'd0);          // one below minimum
      send_fields(ACT_ADD, 32'd1000, 32'd1050, 32'd0);          // exactly minimum
      send_fields(ACT_ADD, 32'd1200, 32'd1100, 32'd0);          // reversed bounds
      send_fields(ACT_ADD, 32'd1050, 32'd1100, 32'd0);          // touching, merges all
      send_fields(ACT_QUERY, 32'd0, 32'd0, 32'd1000);
      send_fields(ACT_QUERY, 32'd0, 32'd0, 32'd1200);           // end is outside
      send_fields(ACT_SETPH, 32'd0, 32'd0, 32'd1100);           // lands in a cut
      send_fields(ACT_UNDO, 32'd0, 32'd0, 32'd0);
      send_fields(ACT_UNDO, 32'd0, 32'd0, 32'd0);               // nothing left to undo
      send_fields(ACT_ADD, 32'd0, 32'hFFFF_FFFF, 32'd0);        // whole range
      send_fields(ACT_SETPH, 32'd0, 32'd0, 32'd5);
      send_fields(ACT_QUERY, 32'd0, 32'd0, 32'hFFFF_FFFF);
      send_fields(ACT_CLEAR, 32'd0, 32'd0, 32'd0);
      send_fields(ACT_UNDO, 32'd0, 32'd0, 32'd0);
      // reversed trim window: every add comes out too short
      set_config(1'b1, 32'd1000, 32'd500, 16'hFFFF);
      send_fields(ACT_ADD, 32'd0, 32'hFFFF_FFFF, 32'd0);
      send_fields(ACT_SETPH, 32'd0, 32'd0, 32'd700);
      // zero minimum admits empty intervals
      set_config(1'b1, 32'd100, 32'd900, 16'd0);
      send_fields(ACT_ADD, 32'd300, 32'd300, 32'd0);
      send_fields(ACT_ADD, 32'd0, 32'd50, 32'd0);               // clamps to an empty cut
      send_fields(ACT_QUERY, 32'd0, 32'd0, 32'd300);
   endtask

   task automatic test_store_full();
      set_config(1'b1, 32'd0, 32'hFFFF_FFFF, 16'd1);
      send_fields(ACT_CLEAR, 32'd0, 32'd0, 32'd0);
      no_gaps = 1'b1;
      for (int i = MAX_INTERVALS - 1; i >= 0; i--)
         send_fields(ACT_ADD, i * 10, i * 10 + 5, 32'd0);
      no_gaps = 1'b0;
      send_fields(ACT_ADD, 32'd1000, 32'd1005, 32'd0);           // one too many
      send_fields(ACT_ADD, 32'd5, 32'd10, 32'd0);                // merges, fits
      send_fields(ACT_QUERY, 32'd0, 32'd0, 32'd7);
      send_fields(ACT_UNDO, 32'd0, 32'd0, 32'd0);
   endtask

   function automatic logic [TIME_W-1:0] pick_time(logic [TIME_W-1:0] lo, int span);
      if ($urandom_range(0, 9) == 0) return $urandom();
      return lo + $urandom_range(0, span);
   endfunction

   task automatic test_random_phase(input int count, input logic [TIME_W-1:0] lo,
                                    input int span);
      req_type r;
      int pick, len;
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         r.start_time = pick_time(lo, span);
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3 * m_minlen + 2)
                                           : $urandom_range(0, span / 8 + 1);
         r.end_time = ($urandom_range(0, 9) == 0) ? $urandom() : r.start_time + len;
         if ($urandom_range(0, 1)) begin
            r.end_time = r.start_time;
            r.start_time = r.start_time + len;
         end
         r.point_time = pick_time(lo, span);
         if (pick < 48) r.action = ACT_ADD;
         else if (pick < 68) r.action = ACT_QUERY;
         else if (pick < 80) r.action = ACT_SETPH;
         else if (pick < 93) r.action = ACT_UNDO;
         else if (pick < 96) r.action = ACT_CLEAR;
         else r.action = ACT_W'($urandom_range(5, 7));
         send_edit(r);
      end
      no_gaps = 1'b0;
   endtask

   task automatic test_random();
      logic [TIME_W-1:0] ts;
      set_config(1'b1, 32'd0, 32'hFFFF_FFFF, MINLEN_RESET);
      test_random_phase(260, 32'd0, 20000);
      set_config(1'b1, 32'hFFFF_0000, 32'hFFFF_FFFF, 16'd3);
      test_random_phase(260, 32'hFFFF_0000, 6000);
      set_config(1'b1, 32'd500, 32'd9000, 16'd0);
      test_random_phase(260, 32'd0, 10000);
      set_config(1'b0, 32'd0, 32'd5000, 16'd10);
      test_random_phase(120, 32'd0, 6000);
      set_config(1'b1, 32'd3000, 32'd1000, 16'd20);
      test_random_phase(120, 32'd0, 5000);
      set_config(1'b1, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);
      test_random_phase(200, 32'd0, 400000);
      for (int p = 0; p < 3; p++) begin
         ts = $urandom();
         set_config(1'b1, ts, ts + $urandom_range(100, 50000),
                    MINLEN_W'($urandom_range(0, 200)));
         test_random_phase(240, ts, 50000);
      end
   endtask

   initial begin
      errors = 0;
      n_items = 0;
      n_results = 0;
      n_add_ok = 0;
      n_full = 0;
      n_cut_hits = 0;
      no_gaps = 1'b0;
      m_media = 1'b0;
      m_tstart = '0;
      m_tend = '0;
      m_minlen = MINLEN_RESET;
      set_n = 0;
      snap_n = 0;
      snap_ok = 1'b0;
      playhead = '0;
      reset = 1'b1;
      start = 1'b0;
      req = '0;
      csr_we = 1'b0;
      csr_index = CSR_MEDIA;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_no_media();
      test_basic_edits();
      test_store_full();
      test_random();

      start <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (END_WAIT) @(posedge clock);

      $display("%0d transactions sent, %0d results checked, %0d mismatches",
               n_items, n_results, errors);
      $display("%0d adds stored, %0d store-full rejects, %0d queries inside a cut",
               n_add_ok, n_full, n_cut_hits);
      if (errors == 0 && expected_rsp_q.size() == 0) begin
         $display("PASS merged_interval_set_with_undo_core");
      end else begin
         $display("FAIL merged_interval_set_with_undo_core");
      end
      $finish;
   end

endmodule

[files.f]
sv/mis_pkg.sv
sv/mis_store.sv
sv/mis_ctrl.sv
sv/merged_interval_set_with_undo_core.sv
bench/tb.sv
